[hdl/sitda_pkg.sv]
// Package for the signed integer to decimal ASCII formatter.
// Holds character codes, widths, the controller state type and the BCD adjust step.
// No dependencies.
package sitda_pkg;

  localparam int ValueW   = 32;
  localparam int CharW    = 8;
  localparam int NumDigits = 10;
  localparam int BcdW     = 4 * NumDigits;
  localparam int BitCntW  = $clog2(ValueW);
  localparam int DigCntW  = $clog2(NumDigits + 1);

  localparam logic [CharW-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CharW-1:0] CHAR_MINUS = 8'd45;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  // Add three to every BCD digit of five or more before the next left shift
  function automatic logic [BcdW-1:0] bcd_adjust(input logic [BcdW-1:0] bcd);
    logic [BcdW-1:0] res;
    res = bcd;
    for (int d = 0; d < NumDigits; d++) begin
      if (bcd[4*d +: 4] >= 4'd5) begin
        res[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
      end
    end
    return res;
  endfunction

endpackage

[hdl/signed_int_to_decimal_ascii.sv]
// Top level: signed 32-bit integer to decimal ASCII text, one character per word.
// Bit-serial binary to BCD conversion (shift and add three), then digit emission.
// Depends on sitda_pkg.
//
// Channel  Direction  Ports                                   Payload
// in       input      in_valid, in_stall, in_value            one signed 32-bit value
// out      output     out_valid, out_stall, out_text_char,    one ASCII character and
//                     out_last_char                           end-of-text flag
//
// An item goes through conversion (one magnitude bit per cycle through the BCD shift
// register), then emission, which skips each leading zero and sends each character,
// a minus sign first for a negative value.
// in_stall is high from acceptance until the last character is in the output register.
// Reset (synchronous, rst_n low) returns the controller to idle and empties the output.
// A stalled output word holds; emission waits until the output register frees up.
module signed_int_to_decimal_ascii
  import sitda_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [ValueW-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [CharW-1:0]         out_text_char,
  output logic                     out_last_char
);

  state_t               state_r, state_nxt;
  logic [ValueW-1:0]    mag_r, mag_nxt;
  logic [BcdW-1:0]      bcd_r, bcd_nxt;
  logic [BitCntW-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [DigCntW-1:0]   dig_cnt_r, dig_cnt_nxt;
  logic                 sign_r, sign_nxt;
  logic                 started_r, started_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CharW-1:0]     out_char_r, out_char_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 in_accept;
  logic                 load_ok;
  logic [3:0]           top_digit;
  logic                 skip_zero;
  logic [BcdW-1:0]      bcd_adj;

  assign in_stall      = (state_r != ST_IDLE);
  assign in_accept     = in_valid && !in_stall;
  assign load_ok       = !out_valid_r || !out_stall;
  assign top_digit     = bcd_r[BcdW-1 -: 4];
  assign skip_zero     = !started_r && (top_digit == 4'd0) && (dig_cnt_r > DigCntW'(1));
  assign bcd_adj       = bcd_adjust(bcd_r);

  assign out_valid     = out_valid_r;
  assign out_text_char = out_char_r;
  assign out_last_char = out_last_r;

  // Sequence conversion and emission
  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    bit_cnt_nxt   = bit_cnt_r;
    dig_cnt_nxt   = dig_cnt_r;
    sign_nxt      = sign_r;
    started_nxt   = started_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          sign_nxt    = in_value[ValueW-1];
          mag_nxt     = in_value[ValueW-1] ? (~in_value + 1'b1) : in_value;
          bcd_nxt     = '0;
          bit_cnt_nxt = '0;
          dig_cnt_nxt = DigCntW'(NumDigits);
          started_nxt = 1'b0;
          state_nxt   = ST_CONV;
        end
      end
      ST_CONV: begin
        // Shift one magnitude bit into the adjusted BCD register
        bcd_nxt     = {bcd_adj[BcdW-2:0], mag_r[ValueW-1]};
        mag_nxt     = {mag_r[ValueW-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + 1'b1;
        if (bit_cnt_r == BitCntW'(ValueW - 1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (skip_zero) begin
          // Drop a leading zero
          bcd_nxt     = {bcd_r[BcdW-5:0], 4'd0};
          dig_cnt_nxt = dig_cnt_r - 1'b1;
        end else if (load_ok) begin
          out_valid_nxt = 1'b1;
          if (sign_r) begin
            out_char_nxt = CHAR_MINUS;
            out_last_nxt = 1'b0;
            sign_nxt     = 1'b0;
          end else begin
            out_char_nxt = CHAR_ZERO + {4'd0, top_digit};
            out_last_nxt = (dig_cnt_r == DigCntW'(1));
            started_nxt  = 1'b1;
            bcd_nxt      = {bcd_r[BcdW-5:0], 4'd0};
            dig_cnt_nxt  = dig_cnt_r - 1'b1;
            if (dig_cnt_r == DigCntW'(1)) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    bcd_r      <= bcd_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    dig_cnt_r  <= dig_cnt_nxt;
    sign_r     <= sign_nxt;
    started_r  <= started_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule
